>>> design/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// shared constants and types for the text terminal with cursor and scroll
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;
  localparam int TAB_SPACES_DEF    = 4;

  localparam int MODE_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int ARG_W        = 8;
  localparam int CELL_W       = 16;
  localparam int CURSOR_COL_W = 7;
  localparam int CURSOR_ROW_W = 5;
  localparam int COLOR_W      = 8;

  localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_RETURN   = 8'd13;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0A;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SET   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cell_cmd_t;

endpackage

>>> design/tts_if.sv
// ----------------------------------------------------------------------------
// tts channel interfaces
// request, result and color register channels with valid/ready
// ----------------------------------------------------------------------------
interface tts_req_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::MODE_W-1:0]  mode;
  logic [tts_pkg::CHAR_W-1:0]  char_code;
  logic [tts_pkg::ARG_W-1:0]   col_arg;
  logic [tts_pkg::ARG_W-1:0]   row_arg;

  modport source (output valid, mode, char_code, col_arg, row_arg, input ready);
  modport sink   (input valid, mode, char_code, col_arg, row_arg, output ready);
endinterface

interface tts_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tts_pkg::CELL_W-1:0]       cell_value;
  logic [tts_pkg::CURSOR_COL_W-1:0] cursor_col;
  logic [tts_pkg::CURSOR_ROW_W-1:0] cursor_row;

  modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_value, cursor_col, cursor_row, output ready);
endinterface

interface tts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::COLOR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/tts_cell_store.sv
// ----------------------------------------------------------------------------
// tts_cell_store
// cell memory organized as a ring of rows; logical rows map through the top
// row offset so a scroll only moves the offset
// ----------------------------------------------------------------------------
module tts_cell_store #(
  parameter int SCREEN_HEIGHT = tts_pkg::SCREEN_HEIGHT_DEF,
  parameter int ROW_W         = 5,
  parameter int COL_W         = 7
) (
  input  logic                       clk,
  input  tts_pkg::cell_cmd_t         cmd,
  input  logic [ROW_W-1:0]           row,
  input  logic [COL_W-1:0]           col,
  input  logic [ROW_W-1:0]           top,
  input  logic [tts_pkg::CELL_W-1:0] wdata,
  output logic [tts_pkg::CELL_W-1:0] rdata
);

  localparam int DEPTH = 1 << (ROW_W + COL_W);

  logic [tts_pkg::CELL_W-1:0] mem [DEPTH];
  logic [ROW_W:0]             row_sum;
  logic [ROW_W:0]             row_wrap;
  logic [ROW_W-1:0]           phys_row;
  logic [ROW_W+COL_W-1:0]     addr;

  assign row_sum  = {1'b0, row} + {1'b0, top};
  assign row_wrap = row_sum - (ROW_W+1)'(SCREEN_HEIGHT);
  assign phys_row = (row_sum >= (ROW_W+1)'(SCREEN_HEIGHT)) ? row_wrap[ROW_W-1:0]
                                                          : row_sum[ROW_W-1:0];
  assign addr     = {phys_row, col};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/text_terminal_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// character-cell text screen with cursor, line wrap, scroll and cell readback
// ----------------------------------------------------------------------------
// After reset the block blanks the screen, one cell per cycle, and takes
// no request until that pass is done; color writes are taken at any time.
// The cell memory has one access per cycle and is organized as a ring of
// rows, so a scroll moves a row offset and only blanks the new bottom row.
// A tab writes TAB_SPACES spaces, and clear screen blanks every cell. A new
// request is accepted while an earlier result still waits in the output
// register.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll #(
  parameter int SCREEN_WIDTH  = tts_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tts_pkg::SCREEN_HEIGHT_DEF,
  parameter int TAB_SPACES    = tts_pkg::TAB_SPACES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tts_req_if.sink    cmd,
  tts_rsp_if.source  result,
  tts_cfg_if.sink    cfg
);

  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int TAB_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [TAB_W-1:0] TAB_LAST = TAB_W'(TAB_SPACES - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [COL_W-1:0]                cur_col, cur_col_next;
  logic [ROW_W-1:0]                cur_row, cur_row_next;
  logic [ROW_W-1:0]                top, top_next;
  logic [TAB_W-1:0]                tab_left, tab_left_next;
  logic [COL_W-1:0]                sw_col, sw_col_next;
  logic [ROW_W-1:0]                sw_row, sw_row_next;
  logic                            sw_all, sw_all_next;
  logic                            init_q, init_q_next;
  logic [tts_pkg::COLOR_W-1:0]     text_color;

  logic [tts_pkg::MODE_W-1:0]      mode_q;
  logic [tts_pkg::CHAR_W-1:0]      ch_q;
  logic [tts_pkg::ARG_W-1:0]       col_q;
  logic [tts_pkg::ARG_W-1:0]       row_q;

  tts_pkg::cell_cmd_t              mem_cmd;
  logic [ROW_W-1:0]                acc_row;
  logic [COL_W-1:0]                acc_col;
  logic [tts_pkg::CELL_W-1:0]      acc_data;
  logic [tts_pkg::CELL_W-1:0]      rdata;

  logic                            finish;
  logic                            load_out;
  logic                            scroll;
  logic                            is_tab;
  logic                            tab_more;
  logic [tts_pkg::CHAR_W-1:0]      ch_put;
  logic [COL_W-1:0]                col_clamp;
  logic [ROW_W-1:0]                row_clamp;
  logic                            req_fire;

  assign req_fire  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign is_tab    = (ch_q == tts_pkg::CH_TAB);
  assign tab_more  = is_tab && (tab_left != '0);
  assign ch_put    = is_tab ? tts_pkg::CH_SPACE : ch_q;
  assign col_clamp = ({1'b0, col_q} >= 9'(SCREEN_WIDTH)) ? LAST_COL : col_q[COL_W-1:0];
  assign row_clamp = ({1'b0, row_q} >= 9'(SCREEN_HEIGHT)) ? LAST_ROW : row_q[ROW_W-1:0];
  assign load_out  = finish && (!result.valid || result.ready);

  always_comb begin
    state_next    = state;
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    top_next      = top;
    tab_left_next = tab_left;
    sw_col_next   = sw_col;
    sw_row_next   = sw_row;
    sw_all_next   = sw_all;
    init_q_next   = init_q;
    mem_cmd       = '0;
    acc_row       = cur_row;
    acc_col       = cur_col;
    acc_data      = {text_color, ch_put};
    finish        = 1'b0;
    scroll        = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          tab_left_next = TAB_LAST;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_q)
          tts_pkg::MODE_PUT: begin
            if (ch_q == tts_pkg::CH_NEWLINE) begin
              cur_col_next = '0;
              if (cur_row == LAST_ROW) begin
                scroll = 1'b1;
              end else begin
                cur_row_next = cur_row + ROW_W'(1);
                finish       = 1'b1;
              end
            end else if (ch_q == tts_pkg::CH_RETURN) begin
              cur_col_next = '0;
              finish       = 1'b1;
            end else begin
              mem_cmd.wr_en = 1'b1;
              if (cur_col == LAST_COL) begin
                cur_col_next = '0;
                if (cur_row == LAST_ROW) begin
                  scroll = 1'b1;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                end
              end else begin
                cur_col_next = cur_col + COL_W'(1);
              end
              if (!scroll) begin
                if (tab_more) begin
                  tab_left_next = tab_left - TAB_W'(1);
                end else begin
                  finish = 1'b1;
                end
              end
            end
          end
          tts_pkg::MODE_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            top_next     = '0;
            sw_col_next  = '0;
            sw_row_next  = '0;
            sw_all_next  = 1'b1;
            state_next   = S_SWEEP;
          end
          tts_pkg::MODE_SET: begin
            cur_col_next = col_clamp;
            cur_row_next = row_clamp;
            finish       = 1'b1;
          end
          default: begin
            mem_cmd.rd_en = 1'b1;
            acc_row       = row_clamp;
            acc_col       = col_clamp;
            state_next    = S_READ;
          end
        endcase
        if (scroll) begin
          top_next     = (top == LAST_ROW) ? '0 : top + ROW_W'(1);
          cur_row_next = LAST_ROW;
          sw_row_next  = LAST_ROW;
          sw_col_next  = '0;
          sw_all_next  = 1'b0;
          state_next   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        mem_cmd.wr_en = 1'b1;
        acc_row       = sw_row;
        acc_col       = sw_col;
        acc_data      = init_q ? {tts_pkg::RESET_COLOR, tts_pkg::CH_SPACE}
                               : {text_color, tts_pkg::CH_SPACE};
        if (sw_col == LAST_COL) begin
          sw_col_next = '0;
          if (sw_all && (sw_row != LAST_ROW)) begin
            sw_row_next = sw_row + ROW_W'(1);
          end else if (init_q) begin
            init_q_next = 1'b0;
            state_next  = S_IDLE;
          end else if (!sw_all && tab_more) begin
            tab_left_next = tab_left - TAB_W'(1);
            state_next    = S_EXEC;
          end else begin
            finish = 1'b1;
          end
        end else begin
          sw_col_next = sw_col + COL_W'(1);
        end
      end
      S_READ: begin
        finish = 1'b1;
      end
      S_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = load_out ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      cur_col  <= '0;
      cur_row  <= '0;
      top      <= '0;
      tab_left <= '0;
      sw_col   <= '0;
      sw_row   <= '0;
      sw_all   <= 1'b1;
      init_q   <= 1'b1;
    end else begin
      state    <= state_next;
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      top      <= top_next;
      tab_left <= tab_left_next;
      sw_col   <= sw_col_next;
      sw_row   <= sw_row_next;
      sw_all   <= sw_all_next;
      init_q   <= init_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tts_pkg::RESET_COLOR;
    end else if (cfg.valid && cfg.ready) begin
      text_color <= cfg.data;
    end
  end

  // request fields
  always_ff @(posedge clk) begin
    if (req_fire) begin
      mode_q <= cmd.mode;
      ch_q   <= cmd.char_code;
      col_q  <= cmd.col_arg;
      row_q  <= cmd.row_arg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.cell_value <= (mode_q == tts_pkg::MODE_READ) ? rdata : '0;
      result.cursor_col <= tts_pkg::CURSOR_COL_W'(cur_col_next);
      result.cursor_row <= tts_pkg::CURSOR_ROW_W'(cur_row_next);
    end
  end

  tts_cell_store #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ROW_W         (ROW_W),
    .COL_W         (COL_W)
  ) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .row   (acc_row),
    .col   (acc_col),
    .top   (top),
    .wdata (acc_data),
    .rdata (rdata)
  );

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= LAST_COL) && (cur_row <= LAST_ROW))
    else $error("cursor outside screen");

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    (top <= LAST_ROW) && (sw_row <= LAST_ROW))
    else $error("row offset outside screen");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_EXEC))
    else $error("request not taken into execution");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_DONE || state == S_IDLE) |-> !mem_cmd.wr_en)
    else $error("cell write outside execution or sweep");

endmodule
